// File: hdl/pcli_pkg.sv
// ----------------------------------------------------------------------------
// pcli_pkg
// Shared types and constants for the pixel color layer indexer.
// ----------------------------------------------------------------------------
package pcli_pkg;

    localparam int DEF_TABLE_DEPTH = 16;

    localparam int PIX_W    = 32;   // red, green, blue, alpha
    localparam int LAYER_W  = 4;
    localparam int SEEN_W   = 5;
    localparam int OUT_W    = 16;   // layer_index + colors_seen, byte padded
    localparam int OFLAG_W  = 3;    // has_layer, new_color, overflow

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_CMP,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic load;      // take the pixel request
        logic rd;        // read table entry at the search index
        logic idx_inc;   // step the search index
        logic fin;       // load the result, append a new color
    } t_cmd;

    typedef struct packed {
        logic transparent;
        logic idx_done;  // search index reached the color count
        logic match;     // entry read last cycle equals the pixel
        logic out_free;  // result register can take a new result
    } t_status;

endpackage

// File: hdl/pixel_color_layer_indexer.sv
// ----------------------------------------------------------------------------
// pixel_color_layer_indexer
// Assigns each opaque RGBA pixel the index of its color in a table of the
// distinct colors of the current image, in order of first appearance.
// ----------------------------------------------------------------------------
// One pixel request is handled at a time. The table is a single-port memory
// searched one entry at a time, each in a read step and then a compare against
// the registered read data. After the accept, a pixel compares k entries,
// where k is the hit position plus one on a hit, the whole color count on a
// miss, and zero for a transparent pixel. A hit goes from its compare straight
// to the finish; a miss or a transparent pixel goes to the finish from the
// look state. The finish step also waits while an earlier result is
// still stalled in the output register. A new pixel is taken while the
// previous result still waits in the output register. A start flag clears the
// count in the same request; no clearing pass is needed after reset.
module pixel_color_layer_indexer import pcli_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [PIX_W-1:0]   s_axis_tdata,   // red, green, blue, alpha
    input  logic               s_axis_tuser,   // start_image
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [OUT_W-1:0]   m_axis_tdata,   // layer_index, colors_seen, zero pad
    output logic [OFLAG_W-1:0] m_axis_tuser    // has_layer, new_color, overflow
);

    t_cmd    cmd;
    t_status status;

    pcli_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    pcli_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_pixel     (s_axis_tdata),
        .i_start     (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_flags (m_axis_tuser)
    );

endmodule

// File: hdl/pcli_ctrl.sv
// ----------------------------------------------------------------------------
// pcli_ctrl
// Sequencer for the table search: accept, read and compare entries, finish.
// ----------------------------------------------------------------------------
module pcli_ctrl import pcli_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                // no request is taken while reset is held
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (i_status.transparent || i_status.idx_done) begin
                    n_state = ST_FIN;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = ST_CMP;
                end
            end
            ST_CMP: begin
                // a hit leaves the index on the matching entry
                if (i_status.match) begin
                    n_state = ST_FIN;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = ST_LOOK;
                end
            end
            ST_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/pcli_dp.sv
// ----------------------------------------------------------------------------
// pcli_dp
// Color table memory, search index, color count and result register.
// ----------------------------------------------------------------------------
module pcli_dp import pcli_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic [PIX_W-1:0]   i_pixel,
    input  logic               i_start,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [OUT_W-1:0]   o_out_data,
    output logic [OFLAG_W-1:0] o_out_flags
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    logic [PIX_W-1:0] r_mem [TABLE_DEPTH];
    logic [PIX_W-1:0] r_pixel;
    logic [PIX_W-1:0] r_rd_data;
    logic [CW-1:0]    r_idx;
    logic [CW-1:0]    r_count;
    logic             r_out_valid;
    logic [OUT_W-1:0]   r_out_data;
    logic [OFLAG_W-1:0] r_out_flags;

    logic          opaque;
    logic          found;
    logic          room;
    logic          add;
    logic [CW-1:0] n_count;

    assign opaque = r_pixel[PIX_W-1 -: 8] != 8'd0;
    // search stops short of the count only on a hit
    assign found  = r_idx < r_count;
    assign room   = r_count < DEPTH_C;
    assign add    = opaque && !found && room;
    assign n_count = add ? r_count + CW'(1) : r_count;

    assign o_status.transparent = !opaque;
    assign o_status.idx_done    = !found;
    assign o_status.match       = r_rd_data == r_pixel;
    assign o_status.out_free    = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[r_idx[IW-1:0]];
        end
        if (i_cmd.fin && add) begin
            r_mem[r_count[IW-1:0]] <= r_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pixel <= i_pixel;
        end
        if (i_cmd.fin) begin
            r_out_data  <= {{(OUT_W - LAYER_W - SEEN_W){1'b0}},
                            SEEN_W'(n_count),
                            (opaque && (found || room)) ? LAYER_W'(r_idx) : LAYER_W'(0)};
            r_out_flags <= {opaque && !found && !room,
                            add,
                            opaque && (found || room)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_idx <= '0;
                if (i_start) begin
                    r_count <= '0;
                end
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.fin) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_flags = r_out_flags;

endmodule

// File: hdl/pcli_checker.sv
// ----------------------------------------------------------------------------
// pcli_checker
// Port-level checks for the pixel color layer indexer, bound to the top level.
// ----------------------------------------------------------------------------
module pcli_checker import pcli_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [OUT_W-1:0]   m_axis_tdata,
    input logic [OFLAG_W-1:0] m_axis_tuser
);

    // one request in flight: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted twice in a row");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_layer_xor_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[2]))
        else $error("overflow with a layer");

    a_new_has_layer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0] && !m_axis_tuser[2])
        else $error("new color without a layer");

    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (TABLE_DEPTH > 31) || (int'(m_axis_tdata[8:4]) <= TABLE_DEPTH))
        else $error("colors seen beyond table depth");

endmodule

bind pixel_color_layer_indexer pcli_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_pcli_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: tb/tb_pixel_color_layer_indexer.sv
// ----------------------------------------------------------------------------
// tb_pixel_color_layer_indexer
// Streams RGBA pixel requests through the color layer indexer with random
// gaps and output stalls, predicts each result from a local copy of the
// color table, and checks every result field in order of arrival.
// ----------------------------------------------------------------------------
module tb_pixel_color_layer_indexer import pcli_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH      = DEF_TABLE_DEPTH;
    localparam int IDLE_LIMIT = 4000;   // cycles without any handshake
    localparam int N_RANDOM   = 2000;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pixel;

    typedef struct packed {
        logic               has_layer;
        logic [LAYER_W-1:0] layer_index;
        logic               new_color;
        logic               overflow;
        logic [SEEN_W-1:0]  colors_seen;
    } t_layer_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [PIX_W-1:0]   s_axis_tdata;   // red, green, blue, alpha
    logic               s_axis_tuser;   // start_image
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [OUT_W-1:0]   m_axis_tdata;   // layer_index, colors_seen, zero pad
    logic [OFLAG_W-1:0] m_axis_tuser;   // has_layer, new_color, overflow

    // local copy of the block's color table
    t_pixel        color_tbl [DEPTH];
    int            color_cnt;
    t_layer_result layer_q [$];

    int err_count  = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    int rx_gap;
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;

    pixel_color_layer_indexer #(
        .TABLE_DEPTH(DEPTH)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // mostly no gap, some short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    // predicted result of one pixel request; updates the local table
    function automatic t_layer_result index_pixel(bit start, t_pixel px);
        t_layer_result r;
        bit            hit;
        r   = '0;
        hit = 1'b0;
        if (start)
            color_cnt = 0;
        if (px.alpha != 8'd0) begin
            for (int k = 0; k < color_cnt; k++) begin
                if (!hit && color_tbl[k] == px) begin
                    hit           = 1'b1;
                    r.layer_index = k[LAYER_W-1:0];
                end
            end
            if (hit) begin
                r.has_layer = 1'b1;
            end else if (color_cnt < DEPTH) begin
                color_tbl[color_cnt] = px;
                r.has_layer   = 1'b1;
                r.new_color   = 1'b1;
                r.layer_index = color_cnt[LAYER_W-1:0];
                color_cnt++;
            end else begin
                r.overflow = 1'b1;
            end
        end
        r.colors_seen = color_cnt[SEEN_W-1:0];
        return r;
    endfunction

    task automatic send_pixel(input bit start, input t_pixel px);
        int gap;
        gap = tx_idle_on ? gap_len() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        s_axis_tuser  <= start;
        do @(posedge i_clk); while (!s_axis_tready);
        layer_q.push_back(index_pixel(start, px));
    endtask

    // hold off new requests until every result is out
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (layer_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_pixel mk_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                        logic [7:0] a);
        t_pixel p;
        p.red   = r;
        p.green = g;
        p.blue  = b;
        p.alpha = a;
        return p;
    endfunction

    // ---------------- directed tests ----------------

    task automatic test_transparent_and_extremes();
        send_pixel(1'b1, mk_pixel(8'hff, 8'hff, 8'hff, 8'h00)); // start on transparent
        send_pixel(1'b0, mk_pixel(8'h00, 8'h00, 8'h00, 8'hff));
        send_pixel(1'b0, mk_pixel(8'hff, 8'hff, 8'hff, 8'hff));
        send_pixel(1'b0, mk_pixel(8'hff, 8'hff, 8'hff, 8'hff)); // hit
    endtask

    // same rgb, different alpha: separate entries
    task automatic test_alpha_distinct();
        send_pixel(1'b1, mk_pixel(8'h12, 8'h34, 8'h56, 8'h01));
        send_pixel(1'b0, mk_pixel(8'h12, 8'h34, 8'h56, 8'h80));
        send_pixel(1'b0, mk_pixel(8'h12, 8'h34, 8'h56, 8'hff));
        send_pixel(1'b0, mk_pixel(8'h12, 8'h34, 8'h56, 8'h80));
    endtask

    // continue the alpha table up to full, then overflow and clear
    task automatic test_table_full();
        for (int i = 3; i < DEPTH; i++)
            send_pixel(1'b0, mk_pixel(8'(i * 17), 8'(255 - i), 8'(i), 8'hc3));
        send_pixel(1'b0, mk_pixel(8'h55, 8'haa, 8'h5a, 8'ha5));     // overflow
        send_pixel(1'b0, mk_pixel(8'((DEPTH - 1) * 17), 8'(256 - DEPTH),
                                  8'(DEPTH - 1), 8'hc3));           // last entry
        send_pixel(1'b0, mk_pixel(8'h00, 8'h00, 8'h00, 8'h00));
        send_pixel(1'b1, mk_pixel(8'h00, 8'h00, 8'h00, 8'h00));     // clear on transparent
        wait_drained();
    endtask

    // ---------------- random images ----------------

    task automatic test_random_images();
        t_pixel palette [24];
        t_pixel px;
        int     n_pal;
        int     n_pix;
        int     sent;
        int     img;
        int     r;
        int     flip;
        sent = 0;
        img  = 0;
        while (sent < N_RANDOM) begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            n_pal = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 24)
                                                : $urandom_range(1, 12);
            for (int j = 0; j < n_pal; j++) begin
                if (j > 0 && $urandom_range(0, 3) == 0) begin
                    // near duplicate of an earlier color
                    palette[j] = palette[$urandom_range(0, j - 1)];
                    flip = $urandom_range(0, PIX_W - 1);
                    palette[j][flip] = ~palette[j][flip];
                end else begin
                    palette[j] = t_pixel'($urandom());
                end
                if (palette[j].alpha == 8'd0)
                    palette[j].alpha = 8'h01;
            end
            n_pix = $urandom_range(5, 60);
            for (int i = 0; i < n_pix; i++) begin
                r = $urandom_range(0, 99);
                if (r < 80) begin
                    px = palette[$urandom_range(0, n_pal - 1)];
                end else if (r < 90) begin
                    px       = t_pixel'($urandom());
                    px.alpha = 8'd0;
                end else begin
                    px = t_pixel'($urandom());
                end
                // a few images carry on without a start flag
                send_pixel(i == 0 && (img % 13 != 12), px);
                sent++;
            end
            img++;
            if (img % 8 == 0)
                wait_drained();
        end
    endtask

    // ---------------- output side ----------------

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            rx_gap = rx_idle_on ? gap_len() : 0;
            if (rx_gap == 0) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b0;
                stall_left = rx_gap - 1;
            end
        end
    end

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_layer_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (layer_q.size() == 0) begin
                $display("%0t: unexpected result, expected none actual tdata=%h tuser=%h",
                         $time, m_axis_tdata, m_axis_tuser);
                err_count++;
            end else begin
                want = layer_q.pop_front();
                check_field("has_layer",   want.has_layer,   m_axis_tuser[0]);
                check_field("new_color",   want.new_color,   m_axis_tuser[1]);
                check_field("overflow",    want.overflow,    m_axis_tuser[2]);
                check_field("layer_index", want.layer_index, m_axis_tdata[LAYER_W-1:0]);
                check_field("colors_seen", want.colors_seen,
                            m_axis_tdata[LAYER_W +: SEEN_W]);
            end
        end
    end

    // watchdog: no request or result moving for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        color_cnt     = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_transparent_and_extremes();
        test_alpha_distinct();
        test_table_full();
        test_random_images();

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (layer_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
